// File: rtl/kdlp_pkg.sv
// Shared types and constants for the keyed decimal line parser.
package kdlp_pkg;

   localparam int MAX_KEY_BYTES = 16;
   localparam int KEY_BITS      = 8 * MAX_KEY_BYTES;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_VT      = 8'h0B;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_KEY_LOW    = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH   = 2'd1;
   localparam logic [1:0] CSR_KEY_LENGTH = 2'd2;

   // Sticky error codes; they double as status codes.
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_INVALID = 2'd1;
   localparam logic [1:0] ERR_RANGE   = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd3;

   // One classified input item as it travels from the front to the back.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       byte_present;
      logic       end_of_text;
      logic       is_newline;
      logic       is_blank;
      logic       is_digit;
      logic [3:0] digit;
   } item_type;

   typedef struct packed {
      logic [1:0]  parse_status;
      logic [63:0] parsed_value;
   } result_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key_bytes;
      logic [4:0]          key_length;
   } cfg_type;

endpackage

// File: rtl/kdlp_fifo.sv
// Small first-in first-out queue used between the parser stages and at the output.
module kdlp_fifo #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_LOG2 = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 1 << DEPTH_LOG2;
   localparam logic [DEPTH_LOG2:0] DEPTH_COUNT = (DEPTH_LOG2 + 1)'(DEPTH);

   logic [WIDTH-1:0]      mem [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_LOG2-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_LOG2:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == DEPTH_COUNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/kdlp_front.sv
// Front stage: accepts input items, drops empty ones and classifies each byte.
module kdlp_front
   import kdlp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_push,
   input  logic     [7:0] in_text_byte,
   input  logic     in_byte_present,
   input  logic     in_end_of_text,
   output logic     in_full,
   output logic     out_push,
   output item_type out_item,
   input  logic     out_full
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept, move;

   assign in_full  = valid_ff && out_full;
   assign accept   = in_push && !in_full;
   assign move     = valid_ff && !out_full;
   assign out_push = valid_ff;
   assign out_item = item_ff;

   always_comb begin
      item_in.text_byte    = in_text_byte;
      item_in.byte_present = in_byte_present;
      item_in.end_of_text  = in_end_of_text;
      item_in.is_newline   = (in_text_byte == CHAR_NEWLINE);
      item_in.is_blank     = (in_text_byte == CHAR_SPACE) || (in_text_byte == CHAR_TAB) ||
                             (in_text_byte == CHAR_CR) || (in_text_byte == CHAR_FF) ||
                             (in_text_byte == CHAR_VT);
      item_in.is_digit     = (in_text_byte >= CHAR_ZERO) && (in_text_byte <= CHAR_NINE);
      item_in.digit        = 4'(in_text_byte - CHAR_ZERO);

      // An item with neither a byte nor an end mark has no effect at all.
      valid_in = valid_ff && !move;
      if (accept && (in_byte_present || in_end_of_text)) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: rtl/kdlp_back.sv
// Back stage: line state machine, key compare, decimal accumulation and result.
module kdlp_back
   import kdlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_empty,
   input  item_type   in_item,
   output logic       in_pop,
   output logic       res_push,
   output result_type res_data,
   input  logic       res_full
);

   typedef enum logic [2:0] {
      PH_BEFORE_KEY,
      PH_IN_KEY,
      PH_BETWEEN,
      PH_IN_VALUE,
      PH_AFTER_VALUE
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [4:0]  key_pos;
      logic        key_match;
      logic        extra;
      logic        nondigit;
      logic        overflow;
      logic [63:0] acc;
      logic        found;
      logic [63:0] kept;
      logic [1:0]  err;
   } line_state_type;

   localparam line_state_type STATE_RESET = '{
      phase: PH_BEFORE_KEY, key_pos: 5'd0, key_match: 1'b1, extra: 1'b0,
      nondigit: 1'b0, overflow: 1'b0, acc: 64'd0, found: 1'b0, kept: 64'd0,
      err: ERR_NONE};

   function automatic line_state_type clear_line(input line_state_type s);
      line_state_type r;
      r           = s;
      r.phase     = PH_BEFORE_KEY;
      r.key_pos   = 5'd0;
      r.key_match = 1'b1;
      r.extra     = 1'b0;
      r.nondigit  = 1'b0;
      r.overflow  = 1'b0;
      r.acc       = 64'd0;
      return r;
   endfunction

   function automatic line_state_type end_line(input line_state_type s,
                                               input logic len_ok,
                                               input logic [4:0] key_len);
      line_state_type r;
      logic           matched;
      r       = s;
      matched = s.key_match && len_ok && (s.key_pos == key_len);
      if (s.err == ERR_NONE && s.phase != PH_BEFORE_KEY) begin
         if (s.phase == PH_IN_KEY || s.phase == PH_BETWEEN || s.extra) begin
            r.err = ERR_INVALID;
         end else if (matched) begin
            if (s.found || s.nondigit) begin
               r.err = ERR_INVALID;
            end else if (s.overflow) begin
               r.err = ERR_RANGE;
            end else begin
               r.found = 1'b1;
               r.kept  = s.acc;
            end
         end
      end
      return clear_line(r);
   endfunction

   line_state_type state_ff, state_in;
   logic           take;
   logic           len_ok;
   logic [7:0]     key_byte;
   logic [67:0]    times_ten;

   assign take     = !in_empty && !res_full;
   assign in_pop   = take;
   assign len_ok   = (cfg.key_length >= 5'd1) &&
                     (cfg.key_length <= 5'(MAX_KEY_BYTES));
   assign key_byte = cfg.key_bytes[8 * state_ff.key_pos[3:0] +: 8];
   // acc * 10 + digit, four guard bits catch any overflow past 64 bits.
   assign times_ten = {1'b0, state_ff.acc, 3'b000} + {3'b000, state_ff.acc, 1'b0} +
                      {64'd0, in_item.digit};

   always_comb begin
      logic key_ok;
      state_in = state_ff;
      key_ok   = len_ok && (state_ff.key_pos < cfg.key_length) &&
                 (key_byte == in_item.text_byte);

      if (in_item.byte_present && state_ff.err == ERR_NONE) begin
         if (in_item.is_newline) begin
            state_in = end_line(state_ff, len_ok, cfg.key_length);
         end else if (in_item.is_blank) begin
            if (state_ff.phase == PH_IN_KEY) begin
               state_in.phase = PH_BETWEEN;
            end else if (state_ff.phase == PH_IN_VALUE) begin
               state_in.phase = PH_AFTER_VALUE;
            end
         end else begin
            case (state_ff.phase)
               PH_BEFORE_KEY, PH_IN_KEY: begin
                  state_in.phase = PH_IN_KEY;
                  if (state_ff.key_match) begin
                     if (key_ok) begin
                        state_in.key_pos = state_ff.key_pos + 5'd1;
                     end else begin
                        state_in.key_match = 1'b0;
                     end
                  end
               end
               PH_BETWEEN, PH_IN_VALUE: begin
                  state_in.phase = PH_IN_VALUE;
                  if (!state_ff.nondigit && !state_ff.overflow) begin
                     if (!in_item.is_digit) begin
                        state_in.nondigit = 1'b1;
                     end else if (times_ten[67:64] != 4'd0) begin
                        state_in.overflow = 1'b1;
                     end else begin
                        state_in.acc = times_ten[63:0];
                     end
                  end
               end
               default: begin
                  state_in.extra = 1'b1;
               end
            endcase
         end
      end

      // The final item closes the open line and produces the result.
      res_data.parse_status = STATUS_MISSING;
      res_data.parsed_value = 64'd0;
      if (in_item.end_of_text) begin
         state_in = end_line(state_in, len_ok, cfg.key_length);
         if (state_in.err != ERR_NONE) begin
            res_data.parse_status = state_in.err;
         end else if (state_in.found) begin
            res_data.parse_status = STATUS_OK;
            res_data.parsed_value = state_in.kept;
         end
         state_in = STATE_RESET;
      end
   end

   assign res_push = take && in_item.end_of_text;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (take) begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/keyed_decimal_line_parser.sv
// Top level of the keyed decimal line parser: registers, stages and queues.
//
// The block reads a text one byte per item on the request queue (req_push /
// req_full) and answers with one item on the response queue (rsp_empty /
// rsp_pop) for every request item that carries end_of_text. The response gives
// parse_status (ok, invalid, range or missing) and the key's decimal value.
// The key and its length are set through the csr_ write port; the user must
// do so only while the block is idle, as the block does not enforce it.
// Index 0 and 1 hold the key bytes, index 2 the key length. A request item
// is registered in the front stage, where it is classified, then waits in a
// short queue until the back stage applies it to the line state. One item
// per cycle is sustained while the receiver keeps popping; the back stage
// does one byte of key compare or one times-ten add per cycle.
// When the receiver stops popping, the response queue fills, the back stage
// halts, then the middle queue and finally req_full rise; nothing is lost.
// Reset clears all queues and the line state and sets the key to all zero
// bytes with a length of one.
module keyed_decimal_line_parser
   import kdlp_pkg::*;
#(
   parameter int QUEUE_DEPTH_LOG2 = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_text,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_parse_status,
   output logic [63:0] rsp_parsed_value,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic [4:0]  key_length_ff;
   cfg_type     cfg;

   logic       mid_push, mid_full, mid_pop, mid_empty;
   item_type   mid_push_item, mid_pop_item;
   logic       res_push, res_full;
   result_type res_data, rsp_data;

   // Configuration registers; writes to an unused index are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= 64'd0;
         key_high_ff   <= 64'd0;
         key_length_ff <= 5'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_LOW:    key_low_ff    <= csr_write_data;
            CSR_KEY_HIGH:   key_high_ff   <= csr_write_data;
            CSR_KEY_LENGTH: key_length_ff <= csr_write_data[4:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.key_bytes  = {key_high_ff, key_low_ff};
   assign cfg.key_length = key_length_ff;

   // Front stage: registers and classifies each request item.
   kdlp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_push         (req_push),
      .in_text_byte    (req_text_byte),
      .in_byte_present (req_byte_present),
      .in_end_of_text  (req_end_of_text),
      .in_full         (req_full),
      .out_push        (mid_push),
      .out_item        (mid_push_item),
      .out_full        (mid_full)
   );

   // The middle queue decouples classification from the line state machine.
   kdlp_fifo #(
      .WIDTH      ($bits(item_type)),
      .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_push_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_pop_item),
      .empty     (mid_empty)
   );

   // Back stage: per-line parsing and the result of each text.
   kdlp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_empty (mid_empty),
      .in_item  (mid_pop_item),
      .in_pop   (mid_pop),
      .res_push (res_push),
      .res_data (res_data),
      .res_full (res_full)
   );

   // Finished results wait here until the receiver pops them.
   kdlp_fifo #(
      .WIDTH      ($bits(result_type)),
      .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   assign rsp_parse_status = rsp_data.parse_status;
   assign rsp_parsed_value = rsp_data.parsed_value;

endmodule

// File: bench/kdlp_parse_check.sv
// Checker for the keyed decimal line parser: follows both queues, predicts and compares.
`timescale 1ns / 1ps

module kdlp_parse_check
   import kdlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_text,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [1:0]  rsp_parse_status,
   input  logic [63:0] rsp_parsed_value,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data,
   output int          fail_count,
   output int          outstanding
);

   typedef enum logic [2:0] {
      LINE_START,
      IN_KEY,
      GAP,
      IN_NUMBER,
      AFTER_NUMBER
   } line_state_type;

   // Shadow of the key registers.
   logic [63:0] key_lo;
   logic [63:0] key_hi;
   logic [4:0]  key_len;

   // Per-line state.
   line_state_type line_state;
   logic [4:0]  key_pos;
   logic        key_alive;
   logic        extra_token;
   logic        bad_digit;
   logic        too_big;
   logic [63:0] number;

   // Per-text state.
   logic        key_seen;
   logic [63:0] found_value;
   logic [1:0]  error_code;

   result_type  status_queue[$];
   result_type  want;
   int          errors = 0;

   assign fail_count = errors;

   function automatic void restart_line();
      line_state  = LINE_START;
      key_pos     = '0;
      key_alive   = 1'b1;
      extra_token = 1'b0;
      bad_digit   = 1'b0;
      too_big     = 1'b0;
      number      = '0;
   endfunction

   function automatic void restart_text();
      restart_line();
      key_seen    = 1'b0;
      found_value = '0;
      error_code  = ERR_NONE;
   endfunction

   function automatic logic is_blank(logic [7:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR ||
             b == CHAR_FF || b == CHAR_VT;
   endfunction

   function automatic void compare_key(logic [7:0] b);
      logic [63:0] word;
      if (!key_alive)
         return;
      if (key_len < 1 || key_len > MAX_KEY_BYTES || key_pos >= key_len) begin
         key_alive = 1'b0;
         return;
      end
      word = (key_pos < 8) ? key_lo : key_hi;
      if (word[8 * key_pos[2:0] +: 8] == b)
         key_pos = key_pos + 1'b1;
      else
         key_alive = 1'b0;
   endfunction

   function automatic void add_digit(logic [7:0] b);
      logic [63:0] d;
      if (bad_digit || too_big)
         return;
      if (b < CHAR_ZERO || b > CHAR_NINE) begin
         bad_digit = 1'b1;
         return;
      end
      d = 64'(b) - 64'(CHAR_ZERO);
      if (number > ({64{1'b1}} - d) / 64'd10)
         too_big = 1'b1;
      else
         number = number * 64'd10 + d;
   endfunction

   function automatic void close_line();
      logic matched;
      if (error_code == ERR_NONE && line_state != LINE_START) begin
         matched = key_alive && key_len >= 1 && key_len <= MAX_KEY_BYTES &&
                   key_pos == key_len;
         if (line_state == IN_KEY || line_state == GAP || extra_token) begin
            error_code = ERR_INVALID;
         end else if (matched) begin
            if (key_seen || bad_digit) begin
               error_code = ERR_INVALID;
            end else if (too_big) begin
               error_code = ERR_RANGE;
            end else begin
               key_seen    = 1'b1;
               found_value = number;
            end
         end
      end
      restart_line();
   endfunction

   function automatic void take_byte(logic [7:0] b);
      if (error_code != ERR_NONE)
         return;
      if (b == CHAR_NEWLINE) begin
         close_line();
         return;
      end
      if (is_blank(b)) begin
         if (line_state == IN_KEY)
            line_state = GAP;
         else if (line_state == IN_NUMBER)
            line_state = AFTER_NUMBER;
         return;
      end
      case (line_state)
         LINE_START: begin
            line_state = IN_KEY;
            compare_key(b);
         end
         IN_KEY: compare_key(b);
         GAP: begin
            line_state = IN_NUMBER;
            add_digit(b);
         end
         IN_NUMBER: add_digit(b);
         default: extra_token = 1'b1;
      endcase
   endfunction

   function automatic void finish_text();
      result_type r;
      close_line();
      if (error_code != ERR_NONE) begin
         r.parse_status = error_code;
         r.parsed_value = '0;
      end else if (key_seen) begin
         r.parse_status = STATUS_OK;
         r.parsed_value = found_value;
      end else begin
         r.parse_status = STATUS_MISSING;
         r.parsed_value = '0;
      end
      status_queue.push_back(r);
      restart_text();
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         key_lo  = '0;
         key_hi  = '0;
         key_len = 5'd1;
         restart_text();
         status_queue.delete();
         outstanding <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_KEY_LOW:    key_lo = csr_write_data;
               CSR_KEY_HIGH:   key_hi = csr_write_data;
               CSR_KEY_LENGTH: key_len = csr_write_data[4:0];
               default: ;
            endcase
         end
         // A result is checked before this edge's input item is applied, so
         // it can never be matched against an expectation made at this edge.
         if (!rsp_empty && rsp_pop) begin
            if (status_queue.size() == 0) begin
               $error("result item with nothing expected: parse_status %0d parsed_value %0d",
                      rsp_parse_status, rsp_parsed_value);
               errors++;
            end else begin
               want = status_queue.pop_front();
               if (rsp_parse_status !== want.parse_status) begin
                  $error("parse_status: expected %0d, got %0d",
                         want.parse_status, rsp_parse_status);
                  errors++;
               end
               if (rsp_parsed_value !== want.parsed_value) begin
                  $error("parsed_value: expected %0d, got %0d",
                         want.parsed_value, rsp_parsed_value);
                  errors++;
               end
            end
         end
         if (req_push && !req_full) begin
            if (req_byte_present)
               take_byte(req_text_byte);
            if (req_end_of_text)
               finish_text();
         end
         outstanding <= status_queue.size();
      end
   end

endmodule

// File: bench/tb_keyed_decimal_line_parser.sv
// Testbench top for the keyed decimal line parser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_keyed_decimal_line_parser;
   import kdlp_pkg::*;

   // Index 3 is not a register; writes to it must leave the key alone.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam int ITEM_TARGET   = 900;
   // Cycles to wait after the last result before touching the registers or
   // giving the verdict.
   localparam int SETTLE_CYCLES = 8;
   // Cycles in a row with no item moving on any port before giving up.
   localparam int STALL_LIMIT   = 2000;

   localparam int END_ANY     = 0;
   localparam int END_ON_BYTE = 1;
   localparam int END_MARKER  = 2;

   typedef enum int {
      LINE_KEY,
      LINE_OTHER,
      LINE_NEAR_KEY,
      LINE_BLANK,
      LINE_ONE_TOKEN,
      LINE_THREE_TOKENS,
      LINE_NOISE
   } line_kind_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_push         = 1'b0;
   logic        req_full;
   logic [7:0]  req_text_byte    = 8'h00;
   logic        req_byte_present = 1'b0;
   logic        req_end_of_text  = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop          = 1'b0;
   logic [1:0]  rsp_parse_status;
   logic [63:0] rsp_parsed_value;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index        = CSR_KEY_LOW;
   logic [63:0] csr_write_data   = 64'd0;

   int          check_failures;
   int          outstanding;

   // The key as last written, used to build lines that match or nearly match.
   logic [63:0] cfg_low  = 64'd0;
   logic [63:0] cfg_high = 64'd0;
   logic [4:0]  cfg_len  = 5'd1;

   // When set, neither side inserts idle cycles.
   bit          steady = 1'b0;
   int          items_sent = 0;
   int          texts_sent = 0;
   int          quiet_cycles = 0;
   logic [7:0]  text_q[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   keyed_decimal_line_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_text_byte    (req_text_byte),
      .req_byte_present (req_byte_present),
      .req_end_of_text  (req_end_of_text),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_parse_status (rsp_parse_status),
      .rsp_parsed_value (rsp_parsed_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   kdlp_parse_check parse_check (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_text_byte    (req_text_byte),
      .req_byte_present (req_byte_present),
      .req_end_of_text  (req_end_of_text),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_parse_status (rsp_parse_status),
      .rsp_parsed_value (rsp_parsed_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (check_failures),
      .outstanding      (outstanding)
   );

   // The receiver stalls about one cycle in four, except in steady stretches.
   always @(posedge clock) begin
      rsp_pop <= steady || ($urandom_range(99) >= 25);
   end

   // The watchdog restarts its count whenever an item or a register write
   // moves. A hang on either queue therefore ends the run as a failure.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_push && !req_full) || (rsp_pop && !rsp_empty) ||
                   csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("keyed_decimal_line_parser: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic is_separator(logic [7:0] b);
      return b == CHAR_NEWLINE || b == CHAR_SPACE || b == CHAR_TAB ||
             b == CHAR_CR || b == CHAR_FF || b == CHAR_VT;
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(4))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_CR;
         3: return CHAR_FF;
         default: return CHAR_VT;
      endcase
   endfunction

   // Any byte that is neither whitespace nor newline counts as a token byte.
   function automatic logic [7:0] pick_token_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (is_separator(b));
      return b;
   endfunction

   function automatic logic [7:0] pick_nondigit();
      logic [7:0] b;
      do
         b = pick_token_byte();
      while (b >= CHAR_ZERO && b <= CHAR_NINE);
      return b;
   endfunction

   // Mostly printable key bytes so that key lines survive as one token, with
   // some arbitrary token bytes and now and then any byte at all.
   function automatic logic [7:0] pick_key_byte();
      int r;
      r = $urandom_range(99);
      if (r < 80)
         return 8'($urandom_range(8'h7E, 8'h21));
      else if (r < 95)
         return pick_token_byte();
      else
         return 8'($urandom_range(255));
   endfunction

   function automatic void push_string(string s);
      for (int i = 0; i < s.len(); i++)
         text_q.push_back(s[i]);
   endfunction

   function automatic void push_blanks(int least);
      repeat ($urandom_range(least + 2, least))
         text_q.push_back(pick_blank());
   endfunction

   function automatic void push_token(int n);
      repeat (n)
         text_q.push_back(pick_token_byte());
   endfunction

   // Pushes the configured key as it stands (mode 0), with one bit flipped
   // (mode 1), with its last byte cut (mode 2) or with a byte added (mode 3).
   // A length the block cannot match leaves only a random token to send.
   function automatic void push_key(int mode);
      int         n;
      int         flip_at;
      logic [7:0] b;
      if (cfg_len == 0 || cfg_len > MAX_KEY_BYTES) begin
         push_token($urandom_range(MAX_KEY_BYTES, 1));
         return;
      end
      n = cfg_len;
      if (mode == 2)
         n--;
      flip_at = (mode == 1) ? $urandom_range(n - 1) : -1;
      for (int i = 0; i < n; i++) begin
         b = (i < 8) ? cfg_low[8 * (i % 8) +: 8] : cfg_high[8 * (i % 8) +: 8];
         if (i == flip_at)
            b = b ^ (8'd1 << $urandom_range(7));
         text_q.push_back(b);
      end
      if (mode == 3)
         text_q.push_back(pick_token_byte());
   endfunction

   // Decimal tokens: small values, full 64-bit values, the exact maximum and
   // one past it, values with an extra digit that may overflow, leading
   // zeros, and numbers with a stray non-digit somewhere inside.
   function automatic void push_number();
      int          r;
      int          junk_at;
      logic [63:0] v;
      string       s;
      r       = $urandom_range(99);
      junk_at = -1;
      v       = {$urandom(), $urandom()} >> $urandom_range(63);
      if (r < 28)
         s = $sformatf("%0d", $urandom_range(999));
      else if (r < 46)
         s = $sformatf("%0d", v);
      else if (r < 54)
         s = "18446744073709551615";
      else if (r < 60)
         s = "18446744073709551616";
      else if (r < 72)
         s = $sformatf("%0d%0d", {$urandom(), $urandom()}, $urandom_range(9));
      else if (r < 78)
         s = $sformatf("000%0d", $urandom_range(99));
      else if (r < 84)
         s = "0";
      else begin
         s       = $sformatf("%0d%0d", v, $urandom_range(9));
         junk_at = $urandom_range(s.len());
      end
      for (int i = 0; i <= s.len(); i++) begin
         if (i == junk_at)
            text_q.push_back(pick_nondigit());
         if (i < s.len())
            text_q.push_back(s[i]);
      end
   endfunction

   function automatic void add_line(line_kind_type kind);
      case (kind)
         LINE_BLANK: begin
            push_blanks(0);
         end
         LINE_NOISE: begin
            repeat ($urandom_range(8, 1))
               text_q.push_back(8'($urandom_range(255)));
         end
         default: begin
            if ($urandom_range(4) == 0)
               push_blanks(1);
            if (kind == LINE_KEY)
               push_key(0);
            else if (kind == LINE_NEAR_KEY)
               push_key($urandom_range(3, 1));
            else
               push_token($urandom_range(8, 1));
            if (kind != LINE_ONE_TOKEN) begin
               push_blanks(1);
               if (kind == LINE_KEY || kind == LINE_NEAR_KEY || $urandom_range(9) < 7)
                  push_number();
               else
                  push_token($urandom_range(6, 1));
            end
            if (kind == LINE_THREE_TOKENS) begin
               push_blanks(1);
               if ($urandom_range(1))
                  push_number();
               else
                  push_token($urandom_range(4, 1));
            end
            if ($urandom_range(4) == 0)
               push_blanks(1);
         end
      endcase
      text_q.push_back(CHAR_NEWLINE);
   endfunction

   // Most lines have the expected two-token shape; the key line is the most
   // common so that accepted values, duplicates and range errors all occur.
   function automatic void build_text();
      int            r;
      line_kind_type kind;
      if ($urandom_range(19) == 0)
         return;
      repeat ($urandom_range(3, 1)) begin
         r    = $urandom_range(99);
         kind = r < 35 ? LINE_KEY :
                r < 58 ? LINE_OTHER :
                r < 68 ? LINE_NEAR_KEY :
                r < 78 ? LINE_BLANK :
                r < 85 ? LINE_ONE_TOKEN :
                r < 92 ? LINE_THREE_TOKENS : LINE_NOISE;
         add_line(kind);
      end
      // Half of the texts end without a final newline.
      if ($urandom_range(1))
         void'(text_q.pop_back());
   endfunction

   // Offers one item and returns at the edge where it is accepted. The sender
   // idles about one cycle in four before an item unless in a steady stretch.
   task automatic drive_item(logic [7:0] b, logic present, logic last);
      while (!steady && $urandom_range(99) < 25) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_text_byte    <= b;
      req_byte_present <= present;
      req_end_of_text  <= last;
      do
         @(posedge clock);
      while (req_full);
      if (present || last)
         items_sent++;
   endtask

   // Sends the text in text_q. The end is flagged either on the last byte or
   // on a separate item that carries no byte. Now and then an item with
   // neither flag is slipped in; the block must ignore it.
   task automatic send_text(int end_mode);
      int n;
      bit end_on_byte;
      n = text_q.size();
      if (end_mode == END_ANY)
         end_on_byte = (n != 0) && ($urandom_range(1) == 1);
      else
         end_on_byte = (end_mode == END_ON_BYTE) && (n != 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 3)
            drive_item(8'($urandom_range(255)), 1'b0, 1'b0);
         drive_item(text_q[i], 1'b1, end_on_byte && (i == n - 1));
      end
      if (!end_on_byte)
         drive_item(8'($urandom_range(255)), 1'b0, 1'b1);
      text_q.delete();
      texts_sent++;
   endtask

   // Waits until every expected result has been popped, then lets the block
   // run dry for a few more cycles.
   task automatic settle();
      req_push <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_KEY_LOW:    cfg_low  = data;
         CSR_KEY_HIGH:   cfg_high = data;
         CSR_KEY_LENGTH: cfg_len  = data[4:0];
         default: ;
      endcase
   endtask

   // Loads a new key. The first settings are the extremes: all-ones bytes at
   // the full length, all-zero bytes with the largest length the field holds,
   // and length zero. Later settings are random, with lengths that cannot
   // match now and then. The length write carries random upper bits.
   task automatic load_key(int setting);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] data;
      logic [4:0]  len;
      int          r;
      for (int i = 0; i < 8; i++) begin
         lo[8 * i +: 8] = pick_key_byte();
         hi[8 * i +: 8] = pick_key_byte();
      end
      r = $urandom_range(99);
      if (r < 12)
         len = $urandom_range(1) ? 5'd0 : 5'($urandom_range(31, MAX_KEY_BYTES + 1));
      else if (r < 30)
         len = 5'(MAX_KEY_BYTES);
      else if (r < 45)
         len = 5'd1;
      else
         len = 5'($urandom_range(MAX_KEY_BYTES, 1));
      case (setting)
         1: begin
            lo  = {64{1'b1}};
            hi  = {64{1'b1}};
            len = 5'(MAX_KEY_BYTES);
         end
         2: begin
            lo  = '0;
            hi  = '0;
            len = 5'd31;
         end
         3: len = 5'd0;
         default: ;
      endcase
      data      = {$urandom(), $urandom()};
      data[4:0] = len;
      write_reg(CSR_KEY_LOW, lo);
      write_reg(CSR_KEY_HIGH, hi);
      write_reg(CSR_KEY_LENGTH, data);
      if (setting % 4 == 3)
         write_reg(CSR_UNUSED, {$urandom(), $urandom()});
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int setting;
      setting = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed texts. The first two run with the key left at reset, a
      // single NUL byte: a NUL key line must give its value, and a text made
      // of nothing but the end flag must report the key as missing.
      text_q.push_back(8'h00);
      text_q.push_back(CHAR_SPACE);
      push_string("5");
      send_text(END_ON_BYTE);
      send_text(END_MARKER);

      settle();
      write_reg(CSR_KEY_LOW, 64'h6B);
      write_reg(CSR_KEY_LENGTH, 64'd1);
      csr_write_enable <= 1'b0;

      // A tab as separator and a text closed by a newline and the end flag.
      push_string("k");
      text_q.push_back(CHAR_TAB);
      push_string("7");
      text_q.push_back(CHAR_NEWLINE);
      send_text(END_MARKER);
      // A line with a single token.
      push_string("k");
      send_text(END_ON_BYTE);
      // A line with three tokens.
      push_string("k 1 2");
      send_text(END_ON_BYTE);
      // A value that is not a number.
      push_string("k x");
      send_text(END_ON_BYTE);
      // The key on two lines.
      push_string("k 1");
      text_q.push_back(CHAR_NEWLINE);
      push_string("k 2");
      send_text(END_ON_BYTE);
      // An ignored item, then a text whose only line holds the byte extremes
      // as tokens between vertical tab, CR and form feed: key missing.
      drive_item(8'hFF, 1'b0, 1'b0);
      text_q.push_back(CHAR_VT);
      text_q.push_back(8'hFF);
      text_q.push_back(CHAR_CR);
      text_q.push_back(8'h00);
      text_q.push_back(CHAR_FF);
      text_q.push_back(CHAR_NEWLINE);
      send_text(END_MARKER);

      // Random texts, with a new key every three texts. A stretch of texts
      // in the middle runs with no idle cycles on either side.
      while (items_sent < ITEM_TARGET) begin
         if (texts_sent % 3 == 0) begin
            settle();
            load_key(setting);
            setting++;
         end
         steady = (texts_sent >= 12 && texts_sent < 18);
         build_text();
         send_text(END_ANY);
      end
      steady = 1'b0;

      settle();
      if (check_failures == 0)
         $display("keyed_decimal_line_parser: match");
      else
         $display("keyed_decimal_line_parser: mismatch");
      $finish;
   end

endmodule
